@@ hdl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with synchronous active-low reset masking
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication form on the same clock and reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    `ASSERT_CLK(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

@@ hdl/frdr_pkg.sv @@
// constants and types for the fresnel dielectric reflectance pipeline
package frdr_pkg;
    localparam int FRAC_BITS   = 15;
    localparam int IOR_W       = 16;
    localparam int OUT_W       = 16;
    localparam int DIV1_STAGES = 15;
    localparam int SQRT_STAGES = 16;
    localparam int RDIV_STAGES = 15;
    localparam int SQ_IN_W     = 31;
    localparam int ROOT_W      = 16;
    localparam int NST         = 56;

    localparam logic [OUT_W-1:0] ONE = 16'd32768;

    localparam logic REG_IOR_INCIDENT = 1'b0;
    localparam logic REG_IOR_TRANSMIT = 1'b1;

    localparam logic [IOR_W-1:0] IOR_INC_RST = 16'd8192;
    localparam logic [IOR_W-1:0] IOR_TRN_RST = 16'd12288;

    typedef struct packed {
        logic [15:0] c;
        logic [15:0] ei;
        logic [15:0] et;
        logic        tir;
    } t_side;
endpackage

@@ hdl/frdr_isqrt.sv @@
// pipelined integer square root, one result bit per stage
module frdr_isqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [frdr_pkg::SQ_IN_W-1:0] i_v,
    output logic [frdr_pkg::ROOT_W-1:0]  o_root
);
    import frdr_pkg::*;

    logic [SQ_IN_W-1:0] r_v   [0:SQRT_STAGES-1];
    logic [31:0]        r_res [0:SQRT_STAGES-1];

    genvar j;
    generate
        for (j = 0; j < SQRT_STAGES; j++) begin : g_st
            logic [SQ_IN_W-1:0] w_v;
            logic [31:0]        w_res;
            logic [31:0]        w_try;
            logic               w_ge;
            if (j == 0) begin : g_first
                assign w_v   = i_v;
                assign w_res = 32'd0;
            end else begin : g_next
                assign w_v   = r_v[j-1];
                assign w_res = r_res[j-1];
            end
            assign w_try = w_res + (32'd1 << (2 * (SQRT_STAGES - 1 - j)));
            assign w_ge  = {1'b0, w_v} >= w_try;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (w_ge) begin
                        r_v[j]   <= SQ_IN_W'({1'b0, w_v} - w_try);
                        r_res[j] <= (w_res >> 1) + (32'd1 << (2 * (SQRT_STAGES - 1 - j)));
                    end else begin
                        r_v[j]   <= w_v;
                        r_res[j] <= w_res >> 1;
                    end
                end
            end
        end
    endgenerate

    assign o_root = r_res[SQRT_STAGES-1][ROOT_W-1:0];
endmodule

@@ hdl/fresnel_dielectric_reflectance_top.sv @@
// fresnel dielectric reflectance: one request in, one reflectance out
// the request-to-result path runs through the pipelined divide and square root stages
// throughput one request per cycle while the output side takes results
// a stalled output holds the whole pipeline in place
// synchronous active-low reset clears valid bits and resets both index registers
module fresnel_dielectric_reflectance_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [frdr_pkg::IOR_W-1:0] i_cfg_data,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [15:0]               s_axis_tdata,  // cos_incident
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [15:0]               m_axis_tdata,  // reflectance
    output logic                      m_axis_tuser   // total_internal
);
    import frdr_pkg::*;

    logic [IOR_W-1:0] r_ior_inc;
    logic [IOR_W-1:0] r_ior_trn;
    logic             r_vld  [0:NST-1];
    t_side            r_side [0:NST-1];
    t_side            n_side0;
    t_side            w_side4;
    logic             adv;
    logic             n_tir;

    assign adv           = !r_vld[NST-1] || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ior_inc <= IOR_INC_RST;
            r_ior_trn <= IOR_TRN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IOR_INCIDENT: r_ior_inc <= i_cfg_data;
                REG_IOR_TRANSMIT: r_ior_trn <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input decode
    logic        w_neg;
    logic        w_enter;
    logic [15:0] w_ei;
    logic [15:0] w_et;

    always_comb begin
        w_neg   = s_axis_tdata[15];
        w_enter = !w_neg && (s_axis_tdata != 16'd0);
        w_ei    = w_enter ? r_ior_inc : r_ior_trn;
        w_et    = w_enter ? r_ior_trn : r_ior_inc;
        n_side0.c   = w_neg ? (~s_axis_tdata + 16'd1) : s_axis_tdata;
        n_side0.ei  = (w_ei == 16'd0) ? 16'd1 : w_ei;
        n_side0.et  = (w_et == 16'd0) ? 16'd1 : w_et;
        n_side0.tir = 1'b0;
    end

    // valid and sideband line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NST; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (adv) begin
            r_vld[0] <= s_axis_tvalid;
            for (int i = 1; i < NST; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_comb begin
        w_side4     = r_side[3];
        w_side4.tir = n_tir;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[0] <= n_side0;
            for (int i = 1; i < NST; i++) begin
                r_side[i] <= (i == 4) ? w_side4 : r_side[i-1];
            end
        end
    end

    // squared sine and snell test
    logic [31:0] r_cc_s1, r_ei2_s1, r_et2_s1;
    logic [15:0] r_s2_s2;
    logic [31:0] r_ei2_s2, r_et2_s2, r_et2_s3, r_et2_s4;
    logic [47:0] r_lhs_s3, r_rem_s4;

    assign n_tir = r_lhs_s3 >= {1'b0, r_et2_s3, 15'd0};

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cc_s1  <= r_side[0].c * r_side[0].c;
            r_ei2_s1 <= r_side[0].ei * r_side[0].ei;
            r_et2_s1 <= r_side[0].et * r_side[0].et;
            r_s2_s2  <= ONE - r_cc_s1[30:15];
            r_ei2_s2 <= r_ei2_s1;
            r_et2_s2 <= r_et2_s1;
            r_lhs_s3 <= r_ei2_s2 * r_s2_s2;
            r_et2_s3 <= r_et2_s2;
            r_rem_s4 <= r_lhs_s3;
            r_et2_s4 <= r_et2_s3;
        end
    end

    // lhs / et^2, restoring, one quotient bit per stage
    logic [47:0] r_d1_rem [0:DIV1_STAGES-1];
    logic [14:0] r_d1_q   [0:DIV1_STAGES-1];
    logic [31:0] r_d1_et2 [0:DIV1_STAGES-1];

    genvar j, l;
    generate
        for (j = 0; j < DIV1_STAGES; j++) begin : g_d1
            logic [47:0] w_rem;
            logic [14:0] w_q;
            logic [31:0] w_et2;
            logic [47:0] w_try;
            logic        w_ge;
            if (j == 0) begin : g_first
                assign w_rem = r_rem_s4;
                assign w_q   = 15'd0;
                assign w_et2 = r_et2_s4;
            end else begin : g_next
                assign w_rem = r_d1_rem[j-1];
                assign w_q   = r_d1_q[j-1];
                assign w_et2 = r_d1_et2[j-1];
            end
            assign w_try = {16'd0, w_et2} << (DIV1_STAGES - 1 - j);
            assign w_ge  = w_rem >= w_try;
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_d1_rem[j] <= w_ge ? (w_rem - w_try) : w_rem;
                    r_d1_q[j]   <= {w_q[13:0], w_ge};
                    r_d1_et2[j] <= w_et2;
                end
            end
        end
    endgenerate

    // transmitted cosine
    logic [15:0]       r_ct2;
    logic [ROOT_W-1:0] w_root;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ct2 <= ONE - {1'b0, r_d1_q[DIV1_STAGES-1]};
        end
    end

    frdr_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_v    ({r_ct2, 15'd0}),
        .o_root (w_root)
    );

    // amplitude ratios, lane 0 parallel, lane 1 perpendicular
    logic [31:0] r_a   [0:1];
    logic [31:0] r_b   [0:1];
    logic [31:0] r_num [0:1];
    logic [31:0] r_den [0:1];
    logic        r_sat [0:1];
    logic [31:0] r_sq  [0:1];
    logic [31:0] r_rd_rem [0:1][0:RDIV_STAGES-1];
    logic [14:0] r_rd_q   [0:1][0:RDIV_STAGES-1];
    logic [31:0] r_rd_den [0:1][0:RDIV_STAGES-1];
    logic        r_rd_sat [0:1][0:RDIV_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a[0] <= r_side[36].et * r_side[36].c;
            r_b[0] <= r_side[36].ei * w_root;
            r_a[1] <= r_side[36].ei * r_side[36].c;
            r_b[1] <= r_side[36].et * w_root;
        end
    end

    generate
        for (l = 0; l < 2; l++) begin : g_lane
            logic [31:0] w_diff;
            logic [31:0] w_sum;
            logic [15:0] w_qf;
            assign w_diff = (r_a[l] >= r_b[l]) ? (r_a[l] - r_b[l]) : (r_b[l] - r_a[l]);
            assign w_sum  = r_a[l] + r_b[l];
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_num[l] <= w_diff;
                    r_den[l] <= w_sum;
                    r_sat[l] <= (w_sum == 32'd0) || (w_diff >= w_sum);
                end
            end
            for (j = 0; j < RDIV_STAGES; j++) begin : g_rd
                logic [31:0] w_rem;
                logic [14:0] w_q;
                logic [31:0] w_den;
                logic        w_sat;
                logic [32:0] w_rem2;
                logic        w_ge;
                if (j == 0) begin : g_first
                    assign w_rem = r_num[l];
                    assign w_q   = 15'd0;
                    assign w_den = r_den[l];
                    assign w_sat = r_sat[l];
                end else begin : g_next
                    assign w_rem = r_rd_rem[l][j-1];
                    assign w_q   = r_rd_q[l][j-1];
                    assign w_den = r_rd_den[l][j-1];
                    assign w_sat = r_rd_sat[l][j-1];
                end
                assign w_rem2 = {w_rem, 1'b0};
                assign w_ge   = w_rem2 >= {1'b0, w_den};
                always_ff @(posedge i_clk) begin
                    if (adv) begin
                        r_rd_rem[l][j] <= w_ge ? 32'(w_rem2 - {1'b0, w_den}) : w_rem2[31:0];
                        r_rd_q[l][j]   <= {w_q[13:0], w_ge};
                        r_rd_den[l][j] <= w_den;
                        r_rd_sat[l][j] <= w_sat;
                    end
                end
            end
            assign w_qf = r_rd_sat[l][RDIV_STAGES-1] ? ONE : {1'b0, r_rd_q[l][RDIV_STAGES-1]};
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_sq[l] <= w_qf * w_qf;
                end
            end
        end
    endgenerate

    // average and output register
    logic [17:0]      w_rsum;
    logic [16:0]      w_r;
    logic [OUT_W-1:0] r_out;

    assign w_rsum = {1'b0, r_sq[0][31:15]} + {1'b0, r_sq[1][31:15]};
    assign w_r    = w_rsum[17:1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_side[54].tir || (w_r > {1'b0, ONE})) begin
                r_out <= ONE;
            end else begin
                r_out <= w_r[15:0];
            end
        end
    end

    assign m_axis_tvalid = r_vld[NST-1];
    assign m_axis_tdata  = r_out;
    assign m_axis_tuser  = r_side[NST-1].tir;
endmodule

@@ hdl/frdr_checker.sv @@
// port-level checks for the reflectance pipeline and their binding
`include "assert_macros.svh"

module frdr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    import frdr_pkg::*;

    `ASSERT_IMPL(a_tir_full, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == ONE, "total internal reflection without full reflectance")
    `ASSERT_IMPL(a_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata <= ONE, "reflectance above one")
    `ASSERT_CLK(a_ready, i_clk, i_rst_n, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready does not follow output stall")
    `ASSERT_IMPL(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, ##1 (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled result changed")
endmodule

bind fresnel_dielectric_reflectance_top frdr_checker u_frdr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ verif/fresnel_dielectric_reflectance_top_tb.sv @@
// testbench for the fresnel dielectric reflectance pipeline with a built-in predictor
`timescale 1ns / 1ps

module fresnel_dielectric_reflectance_top_tb;
    import frdr_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int RAND_PER_PHASE = 60;
    localparam int N_SETTINGS     = 8;

    typedef struct packed {
        logic [15:0] refl;
        logic        tir;
    } reflect_t;

    typedef struct {
        logic [15:0] cosv;
        logic        typed;
        reflect_t    want;
    } dir_row_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic              i_cfg_idx;
    logic [IOR_W-1:0]  i_cfg_data;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [15:0]       m_axis_tdata;
    logic              m_axis_tuser;

    logic [15:0] ior_inc_q;
    logic [15:0] ior_trn_q;
    reflect_t    pending_refl[$];
    int          mismatches;
    int          idle_cycles;
    int          burst_left;
    int          stall_mode;
    int          stall_left;
    logic        typed_armed;
    reflect_t    typed_want;

    dir_row_t dir_rows[$];
    logic [15:0] set_inc[N_SETTINGS];
    logic [15:0] set_trn[N_SETTINGS];

    fresnel_dielectric_reflectance_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint unsigned amp_ratio_sq(longint unsigned a, longint unsigned b);
        longint unsigned diff;
        longint unsigned den;
        longint unsigned q;
        diff = (a >= b) ? a - b : b - a;
        den  = a + b;
        if (den == 0 || diff >= den) begin
            q = 64'd1 << FRAC_BITS;
        end else begin
            q = (diff << FRAC_BITS) / den;
        end
        return (q * q) >> FRAC_BITS;
    endfunction

    function automatic reflect_t fresnel_predict(logic [15:0] cosv, logic [15:0] inc,
                                                 logic [15:0] trn);
        longint unsigned one_q;
        longint unsigned mag;
        longint unsigned ei;
        longint unsigned et;
        longint unsigned c;
        longint unsigned s2;
        longint unsigned lhs;
        longint unsigned rhs;
        longint unsigned ct2;
        longint unsigned ct;
        longint unsigned trial;
        longint unsigned r;
        logic entering;
        reflect_t res;
        one_q = 64'd1 << FRAC_BITS;
        entering = !cosv[15] && cosv != 16'd0;
        mag = cosv[15] ? (64'h10000 - cosv) : cosv;
        ei = entering ? inc : trn;
        et = entering ? trn : inc;
        if (ei == 0) ei = 1;
        if (et == 0) et = 1;
        c = (mag > one_q) ? one_q : mag;
        s2 = one_q - ((c * c) >> FRAC_BITS);
        lhs = ei * ei * s2;
        rhs = et * et * one_q;
        if (lhs >= rhs) begin
            res.refl = ONE;
            res.tir  = 1'b1;
            return res;
        end
        ct2 = one_q - lhs / (et * et);
        ct = 0;
        for (int b = 17; b >= 0; b--) begin
            trial = ct | (64'd1 << b);
            if (trial * trial <= (ct2 << FRAC_BITS)) ct = trial;
        end
        r = (amp_ratio_sq(et * c, ei * ct) + amp_ratio_sq(ei * c, et * ct)) >> 1;
        if (r > one_q) r = one_q;
        if (r > 32768) r = 32768;
        res.refl = r[15:0];
        res.tir  = 1'b0;
        return res;
    endfunction

    task automatic cfg_write(logic idx, logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        if (idx == REG_IOR_INCIDENT) ior_inc_q = value;
        else ior_trn_q = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_cos(logic [15:0] cosv);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 12)) @(negedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cosv;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_refl.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_cos();
        case ($urandom_range(0, 3))
            0: return 16'($signed($urandom_range(0, 600)) - 300);
            1: return 16'(32767 - $urandom_range(0, 400));
            2: return 16'(-32768 + $urandom_range(0, 400));
            default: return 16'($urandom);
        endcase
    endfunction

    // request accepted: queue the expected reflectance
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            if (typed_armed) begin
                pending_refl.push_back(typed_want);
            end else begin
                pending_refl.push_back(fresnel_predict(s_axis_tdata, ior_inc_q, ior_trn_q));
            end
        end
    end

    always @(posedge i_clk) begin
        reflect_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_refl.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result refl=%0d tir=%0b", m_axis_tdata, m_axis_tuser);
            end else begin
                want = pending_refl.pop_front();
                if (m_axis_tdata !== want.refl || m_axis_tuser !== want.tir) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected refl=%0d tir=%0b, got refl=%0d tir=%0b",
                                 want.refl, want.tir, m_axis_tdata, m_axis_tuser);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 9) < 7);
            2: m_axis_tready <= ($urandom_range(0, 9) < 3);
            default: m_axis_tready <= (stall_left % 8) < 5;
        endcase
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        dir_row_t row;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_IOR_INCIDENT;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        ior_inc_q     = IOR_INC_RST;
        ior_trn_q     = IOR_TRN_RST;
        mismatches    = 0;
        idle_cycles   = 0;
        burst_left    = 0;
        stall_left    = 0;
        stall_mode    = 0;
        typed_armed   = 1'b0;
        typed_want    = '0;

        // grazing exit at reset indices is total internal reflection
        dir_rows.push_back('{16'h0000, 1'b1, '{ONE, 1'b1}});
        dir_rows.push_back('{16'h8000, 1'b0, '0});
        dir_rows.push_back('{16'h7FFF, 1'b0, '0});
        dir_rows.push_back('{16'h0001, 1'b0, '0});
        dir_rows.push_back('{16'hFFFF, 1'b1, '{ONE, 1'b1}});
        dir_rows.push_back('{16'h4000, 1'b0, '0});
        dir_rows.push_back('{16'hC000, 1'b0, '0});
        dir_rows.push_back('{16'h5555, 1'b0, '0});
        dir_rows.push_back('{16'hAAAA, 1'b0, '0});
        dir_rows.push_back('{16'h8001, 1'b0, '0});
        dir_rows.push_back('{16'h1000, 1'b0, '0});
        dir_rows.push_back('{16'hF000, 1'b0, '0});

        set_inc = '{16'd8192, 16'd1, 16'd65535, 16'd0, 16'd8192, 16'd65535, 16'd10923, 16'd0};
        set_trn = '{16'd12288, 16'd65535, 16'd1, 16'd0, 16'd8192, 16'd65535, 16'd9000, 16'd1};

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int s = 0; s < N_SETTINGS; s++) begin
            if (s > 0) begin
                cfg_write(REG_IOR_INCIDENT, set_inc[s]);
                cfg_write(REG_IOR_TRANSMIT, set_trn[s]);
            end
            foreach (dir_rows[k]) begin
                row = dir_rows[k];
                typed_armed = (s == 0) && row.typed;
                typed_want  = row.want;
                send_cos(row.cosv);
                typed_armed = 1'b0;
            end
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                send_cos(rand_cos());
                // let the pipeline empty once mid-phase
                if (s == 2 && n == RAND_PER_PHASE / 2) wait_drained();
            end
            wait_drained();
        end
        for (int n = 0; n < 30; n++) begin
            cfg_write(REG_IOR_INCIDENT, 16'($urandom));
            cfg_write(REG_IOR_TRANSMIT, 16'($urandom));
            repeat (4) send_cos(rand_cos());
            wait_drained();
        end

        if (pending_refl.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
